>>> design/quadtree_uniform_block_counter_assert.svh
// assertion macros used by the controller module
// both expect clk_i and rst_ni in scope
`ifndef QUADTREE_UNIFORM_BLOCK_COUNTER_ASSERT_SVH
`define QUADTREE_UNIFORM_BLOCK_COUNTER_ASSERT_SVH

// same-cycle implication
`define QUBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qubc assertion failed");

// next-cycle implication
`define QUBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qubc assertion failed");

`endif

>>> design/qubc_pkg.sv
`timescale 1ns / 1ps
package qubc_pkg;

  localparam int CntW = 15;
  localparam int SideLog2W = 3;
  localparam int MaxLevels = 7;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } qubc_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic scan_rd;
    logic load_out;
    logic cfg_we;
  } qubc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_pix;
    logic scan_last;
  } qubc_sts_t;

endpackage

>>> design/quadtree_uniform_block_counter.sv
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// in        sink       in_valid_i / in_stall_o   pixel_i
// out       source     out_valid_o / out_stall_i white_count_o, black_count_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_side_log2_i
//
// pixels load one per cycle while not scanning, draining or handing off, and are
// written to the image store at their z-order address; after the last of the
// 4^k pixels the store is read back once in z-order, one cell a cycle, then the
// read stage drains and the result is handed off before it shows
// no pixel is taken during the scan, the read drain or the hand-off
// the result sits in an output register, so loading of the next image runs on
// while it waits; the hand-off waits only while that register is full and stalled
// reset clears the control state and the tallies; no clearing pass on the store
module quadtree_uniform_block_counter import qubc_pkg::*; #(
  parameter int MAX_SIDE = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 pixel_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CntW-1:0]      white_count_o,
  output logic [CntW-1:0]      black_count_o,
  // side register write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SideLog2W-1:0] cfg_side_log2_i
);

  // largest power of two not above the maximum side, capped by the register range
  localparam int LgRaw = $clog2(MAX_SIDE + 1) - 1;
  localparam int MaxLg = (LgRaw > MaxLevels) ? MaxLevels : LgRaw;

  qubc_cmd_t cmd;
  qubc_sts_t sts;

  // sequencing: load, scan, drain of the read stage, hand-off to the output
  qubc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, position counters and the bottom-up merge of quadrants
  qubc_dp #(
    .MaxLg (MaxLg)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pixel_i         (pixel_i),
    .cfg_side_log2_i (cfg_side_log2_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .white_count_o   (white_count_o),
    .black_count_o   (black_count_o)
  );

endmodule

>>> design/qubc_ctrl.sv
`timescale 1ns / 1ps
module qubc_ctrl import qubc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  qubc_sts_t sts_i,
  output qubc_cmd_t cmd_o
);

  qubc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o   = 1'b0;
        cfg_ready_o  = 1'b1;
        cmd_o.cfg_we = cfg_valid_i;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.last_pix) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

`include "quadtree_uniform_block_counter_assert.svh"

  `QUBC_ASSERT_NEXT(a_start_scans, cmd_o.start, state_q == ST_SCAN && cmd_o.scan_rd)
  `QUBC_ASSERT_NEXT(a_load_shows, cmd_o.load_out, out_valid_q)
  `QUBC_ASSERT_NEXT(a_drain_once, state_q == ST_DRAIN, state_q == ST_FINISH)
  `QUBC_ASSERT_NOW(a_no_cfg_in_scan, cmd_o.cfg_we, !cmd_o.scan_rd && !cmd_o.load_out)

endmodule

>>> design/qubc_dp.sv
`timescale 1ns / 1ps
module qubc_dp import qubc_pkg::*; #(
  parameter int MaxLg = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pixel_i,
  input  logic [SideLog2W-1:0] cfg_side_log2_i,
  input  qubc_cmd_t            cmd_i,
  output qubc_sts_t            sts_o,
  output logic [CntW-1:0]      white_count_o,
  output logic [CntW-1:0]      black_count_o
);

  localparam int CW = (MaxLg > 0) ? MaxLg : 1;
  localparam int AW = (MaxLg > 0) ? 2 * MaxLg : 1;
  localparam int Depth = 1 << (2 * MaxLg);
  localparam int LN = (MaxLg > 0) ? MaxLg : 1;

  // active side exponent, already clamped to the store
  logic [SideLog2W-1:0] k_q, k_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] side_mask;
  logic [AW-1:0] wr_addr, scan_addr_q, scan_addr_d, scan_end;

  logic mem [Depth];
  logic rd_pix_q;
  logic rd_vld_q;

  // per level merge state
  logic [1:0] lv_cnt_q [LN];
  logic [1:0] lv_cnt_d [LN];
  logic       lv_same_q [LN];
  logic       lv_same_d [LN];
  logic       lv_col_q [LN];
  logic       lv_col_d [LN];
  logic [2:0] lv_pw_q [LN];
  logic [2:0] lv_pw_d [LN];
  logic [2:0] lv_pb_q [LN];
  logic [2:0] lv_pb_d [LN];

  logic [CntW-1:0] wt_q, wt_d, bt_q, bt_d;
  logic [CntW-1:0] wout_q, bout_q;
  logic [5:0] add_w, add_b;

  assign side_mask = CW'((32'd1 << k_q) - 32'd1);
  assign scan_end  = AW'((32'd1 << {k_q, 1'b0}) - 32'd1);

  assign sts_o.last_pix  = (row_q == side_mask) && (col_q == side_mask);
  assign sts_o.scan_last = (scan_addr_q == scan_end);

  // z-order address of the raster position
  always_comb begin
    wr_addr = '0;
    for (int i = 0; i < MaxLg; i++) begin
      wr_addr[2*i]   = col_q[i];
      wr_addr[2*i+1] = row_q[i];
    end
  end

  always_comb begin
    k_d   = k_q;
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.cfg_we) begin
      k_d   = (int'(cfg_side_log2_i) > MaxLg) ? SideLog2W'(MaxLg) : cfg_side_log2_i;
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.accept) begin
      if (col_q == side_mask) begin
        col_d = '0;
        row_d = (row_q == side_mask) ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    scan_addr_d = scan_addr_q;
    if (cmd_i.start) begin
      scan_addr_d = '0;
    end else if (cmd_i.scan_rd && !sts_o.scan_last) begin
      scan_addr_d = scan_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= SideLog2W'(MaxLg);
      row_q       <= '0;
      col_q       <= '0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      k_q         <= k_d;
      row_q       <= row_d;
      col_q       <= col_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wr_addr] <= pixel_i;
    end
    if (cmd_i.scan_rd) begin
      rd_pix_q <= mem[scan_addr_q];
    end
  end

  // merge one pixel upward through the levels
  always_comb begin
    logic node_vld;
    logic node_uni;
    logic node_col;
    logic same_n;
    logic [2:0] pw_n;
    logic [2:0] pb_n;
    node_vld = rd_vld_q;
    node_uni = 1'b1;
    node_col = rd_pix_q;
    same_n   = 1'b0;
    pw_n     = '0;
    pb_n     = '0;
    add_w    = '0;
    add_b    = '0;
    if (rd_vld_q && k_q == '0) begin
      add_w = {5'd0, ~rd_pix_q};
      add_b = {5'd0, rd_pix_q};
    end
    for (int l = 0; l < LN; l++) begin
      lv_cnt_d[l]  = lv_cnt_q[l];
      lv_same_d[l] = lv_same_q[l];
      lv_col_d[l]  = lv_col_q[l];
      lv_pw_d[l]   = lv_pw_q[l];
      lv_pb_d[l]   = lv_pb_q[l];
      if (cmd_i.start) begin
        lv_cnt_d[l] = '0;
        node_vld    = 1'b0;
      end else if (node_vld && l < int'(k_q)) begin
        if (lv_cnt_q[l] == 2'd0) begin
          same_n      = node_uni;
          lv_col_d[l] = node_col;
          pw_n        = {2'd0, node_uni & ~node_col};
          pb_n        = {2'd0, node_uni & node_col};
        end else begin
          same_n = lv_same_q[l] & node_uni & (node_col == lv_col_q[l]);
          pw_n   = lv_pw_q[l] + {2'd0, node_uni & ~node_col};
          pb_n   = lv_pb_q[l] + {2'd0, node_uni & node_col};
        end
        lv_same_d[l] = same_n;
        lv_pw_d[l]   = pw_n;
        lv_pb_d[l]   = pb_n;
        lv_cnt_d[l]  = lv_cnt_q[l] + 2'd1;
        if (lv_cnt_q[l] == 2'd3) begin
          // mixed parent: its uniform children are leaves
          if (!same_n) begin
            add_w = add_w + {3'd0, pw_n};
            add_b = add_b + {3'd0, pb_n};
          end else if (l + 1 == int'(k_q)) begin
            // uniform root
            add_w = add_w + {5'd0, ~lv_col_d[l]};
            add_b = add_b + {5'd0, lv_col_d[l]};
          end
          node_vld = (l + 1 < int'(k_q));
          node_uni = same_n;
          node_col = lv_col_d[l];
        end else begin
          node_vld = 1'b0;
        end
      end else begin
        node_vld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LN; l++) begin
        lv_cnt_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LN; l++) begin
        lv_cnt_q[l] <= lv_cnt_d[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LN; l++) begin
      lv_same_q[l] <= lv_same_d[l];
      lv_col_q[l]  <= lv_col_d[l];
      lv_pw_q[l]   <= lv_pw_d[l];
      lv_pb_q[l]   <= lv_pb_d[l];
    end
  end

  always_comb begin
    if (cmd_i.start || cmd_i.cfg_we) begin
      wt_d = '0;
      bt_d = '0;
    end else begin
      wt_d = wt_q + CntW'(add_w);
      bt_d = bt_q + CntW'(add_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= '0;
      bt_q <= '0;
    end else begin
      wt_q <= wt_d;
      bt_q <= bt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      wout_q <= wt_q;
      bout_q <= bt_q;
    end
  end

  assign white_count_o = wout_q;
  assign black_count_o = bout_q;

endmodule
